// ===== hw/rtl/hashed_key_value_registry_defines.svh =====
// ----------------------------------------------------------------------------
// Hashed key/value registry: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef HASHED_KEY_VALUE_REGISTRY_DEFINES_SVH
`define HASHED_KEY_VALUE_REGISTRY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HKVR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HKVR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/hkvr_pkg.sv =====
// ----------------------------------------------------------------------------
// Hashed key/value registry package
// Shared constants, result codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package hkvr_pkg;

  // Default sizing of the slot table.
  localparam int TABLE_SLOTS_DEF = 64;
  localparam int MAX_ENTRIES_DEF = 64;

  // Hash and home-slot reduction schedule.
  localparam int HASH_STEPS         = 6;
  localparam int MOD_BITS_PER_CYCLE = 4;
  localparam int MOD_CYCLES         = 64 / MOD_BITS_PER_CYCLE;
  localparam int STEP_W             = 4;

  localparam logic [63:0] HASH_XOR_MASK = 64'h0000_0000_7FFF_FFFF;

  // Operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_MISSING  = 2'd2;
  localparam logic [1:0] ST_ZERO_KEY = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;       // capture the input item
    logic              clr;        // write one empty slot of the clearing pass
    logic              hash;       // run one mix step
    logic              modr;       // run one reduction cycle
    logic [STEP_W-1:0] step;       // step index for hash and reduction
    logic              pstart;     // start the probe at the home slot
    logic              probe;      // read the next slot
    logic              ins_write;  // store the item in the slot just matched
    logic              fin;        // capture the result
    logic [1:0]        fin_status;
    logic              fin_value;  // take the found value from the slot read
    logic              out_load;   // move the result to the output register
  } hkvr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic key_zero;
    logic op_lookup;
    logic table_full;
    logic clr_last;
    logic hit;
    logic probe_end;
  } hkvr_stat_t;

endpackage

// ===== hw/rtl/hashed_key_value_registry.sv =====
// ----------------------------------------------------------------------------
// Hashed key/value registry
// Open-addressed table of 64-bit values keyed by 64-bit keys, linear probing.
// ----------------------------------------------------------------------------
//  Channel  | Handshake           | Fields
//  ---------+---------------------+-----------------------------------------
//  input    | in_valid / in_ready | op, key, value
//  output   | out_valid/out_ready | status, found_value
//
// After reset the slot table is cleared one slot a cycle, with in_ready low.
// An item is captured, hashed, reduced to its home slot, probed slot by slot from there up to
// the last slot, and its result is loaded into the output register; a zero key, or an insert
// into a full table, skips the hash, the reduction and the probe.
// The slot RAM read port, one slot a cycle, sets the probe length.
// A waiting result blocks the next item only once that item is ready to deliver.
// ----------------------------------------------------------------------------
module hashed_key_value_registry #(
  parameter int TABLE_SLOTS = hkvr_pkg::TABLE_SLOTS_DEF,
  parameter int MAX_ENTRIES = hkvr_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [63:0] key,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [63:0] found_value
);

  import hkvr_pkg::*;

  hkvr_cmd_t  cmd;
  hkvr_stat_t stat;

  // Sequencer.
  hkvr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hash, probe and slot storage.
  hkvr_datapath #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .key        (key),
    .value      (value),
    .cmd        (cmd),
    .stat       (stat),
    .status     (status),
    .found_value(found_value)
  );

endmodule

// ===== hw/rtl/hkvr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hkvr_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/hkvr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Hashed key/value registry controller
// Sequences the clearing pass, hashing, reduction, probe and result delivery.
// ----------------------------------------------------------------------------
module hkvr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  hkvr_pkg::hkvr_stat_t stat,
  output hkvr_pkg::hkvr_cmd_t  cmd
);

  import hkvr_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_MOD,
    S_PSTART,
    S_PROBE,
    S_EMIT
  } state_t;

  state_t            state, state_next;
  logic [STEP_W-1:0] cnt, cnt_next;
  logic              out_valid_next;

  assign in_ready = (state == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.step   = cnt;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (stat.key_zero) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = ST_ZERO_KEY;
          state_next     = S_EMIT;
        end else if (!stat.op_lookup && stat.table_full) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = ST_FULL;
          state_next     = S_EMIT;
        end else begin
          cmd.hash = 1'b1;
          if (cnt == STEP_W'(HASH_STEPS - 1)) begin
            cnt_next   = '0;
            state_next = S_MOD;
          end else begin
            cnt_next = cnt + STEP_W'(1);
          end
        end
      end
      S_MOD: begin
        cmd.modr = 1'b1;
        if (cnt == STEP_W'(MOD_CYCLES - 1)) begin
          state_next = S_PSTART;
        end else begin
          cnt_next = cnt + STEP_W'(1);
        end
      end
      S_PSTART: begin
        cmd.pstart = 1'b1;
        state_next = S_PROBE;
      end
      S_PROBE: begin
        if (stat.hit) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = ST_OK;
          cmd.fin_value  = stat.op_lookup;
          cmd.ins_write  = !stat.op_lookup;
          state_next     = S_EMIT;
        end else if (stat.probe_end) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = stat.op_lookup ? ST_MISSING : ST_FULL;
          state_next     = S_EMIT;
        end else begin
          cmd.probe = 1'b1;
        end
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output valid follows the output register load and the downstream take.
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== hw/rtl/hkvr_datapath.sv =====
// ----------------------------------------------------------------------------
// Hashed key/value registry datapath
// Item capture, mix hash, home-slot reduction, slot RAM, probe and result.
// ----------------------------------------------------------------------------
module hkvr_datapath #(
  parameter int TABLE_SLOTS = hkvr_pkg::TABLE_SLOTS_DEF,
  parameter int MAX_ENTRIES = hkvr_pkg::MAX_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                op,
  input  logic [63:0]         key,
  input  logic [63:0]         value,
  input  hkvr_pkg::hkvr_cmd_t  cmd,
  output hkvr_pkg::hkvr_stat_t stat,
  output logic [1:0]          status,
  output logic [63:0]         found_value
);

  import hkvr_pkg::*;

  localparam int AW  = $clog2(TABLE_SLOTS);
  localparam int RW  = $clog2(MAX_ENTRIES + 1);
  localparam int TSW = $clog2(TABLE_SLOTS + 1);
  localparam int PW  = (TSW > RW) ? TSW : RW;

  localparam logic [RW:0]   MOD_M    = (RW + 1)'(MAX_ENTRIES);
  localparam logic [PW-1:0] SLOTS_P  = PW'(TABLE_SLOTS);
  localparam logic [PW-1:0] LAST_P   = PW'(TABLE_SLOTS - 1);
  localparam logic [RW-1:0] ENTRIES_C = RW'(MAX_ENTRIES);

  // Captured item and working registers.
  logic          op_r;
  logic [63:0]   key_r;
  logic [63:0]   value_r;
  logic [63:0]   h, h_next;
  logic [63:0]   msr;
  logic [RW-1:0] rem;
  logic [PW-1:0] paddr;
  logic          pend;
  logic [AW-1:0] pend_addr;
  logic [RW-1:0] entry_count;
  logic [1:0]    res_status;
  logic [63:0]   res_value;

  // Reduction temporaries.
  logic [63:0]   mix_m;
  logic [63:0]   mod_src;
  logic [RW-1:0] r;
  logic [RW:0]   t;

  // Slot RAM signals: key in the upper half, value in the lower half.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [127:0]  ram_wdata;
  logic [127:0]  ram_rdata;
  logic [63:0]   rd_key;
  logic [63:0]   rd_val;
  logic          in_range;
  logic          match;

  // One step of the 64-bit integer mix per cycle.
  always_comb begin
    case (cmd.step)
      STEP_W'(0): h_next = (~key_r) + (key_r << 18);
      STEP_W'(1): h_next = h ^ (h >> 31);
      STEP_W'(2): h_next = h + (h << 2) + (h << 4);
      STEP_W'(3): h_next = h ^ (h >> 11);
      STEP_W'(4): h_next = h + (h << 6);
      STEP_W'(5): h_next = h ^ (h >> 22);
      default:    h_next = h;
    endcase
  end

  // Home slot reduction: restoring remainder, a few bits per cycle, MSB first.
  assign mix_m = {3'b000, h[63:3]} ^ HASH_XOR_MASK;

  always_comb begin
    mod_src = (cmd.step == '0) ? mix_m : msr;
    r       = (cmd.step == '0) ? '0 : rem;
    t       = '0;
    for (int j = 0; j < MOD_BITS_PER_CYCLE; j++) begin
      t = {r, mod_src[63-j]};
      if (t >= MOD_M) begin
        t = t - MOD_M;
      end
      r = t[RW-1:0];
    end
  end

  // Slot RAM access.
  assign ram_we    = cmd.clr | cmd.ins_write;
  assign ram_waddr = cmd.clr ? paddr[AW-1:0] : pend_addr;
  assign ram_wdata = cmd.clr ? '0 : {key_r, value_r};
  assign rd_key    = ram_rdata[127:64];
  assign rd_val    = ram_rdata[63:0];

  hkvr_ram #(
    .WIDTH(128),
    .DEPTH(TABLE_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(paddr[AW-1:0]),
    .rdata(ram_rdata)
  );

  // Probe compare: an insert looks for an empty slot, a lookup for its key.
  assign in_range = (paddr < SLOTS_P);
  assign match    = (op_r == OP_LOOKUP) ? (rd_key == key_r) : (rd_key == '0);

  // Status to the controller.
  always_comb begin
    stat            = '0;
    stat.key_zero   = (key_r == '0);
    stat.op_lookup  = (op_r == OP_LOOKUP);
    stat.table_full = (entry_count >= ENTRIES_C);
    stat.clr_last   = (paddr == LAST_P);
    stat.hit        = pend && match;
    stat.probe_end  = !pend && !in_range;
  end

  // Control state: probe pointer, outstanding read and entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      paddr       <= '0;
      pend        <= 1'b0;
      entry_count <= '0;
    end else begin
      if (cmd.clr) begin
        paddr <= paddr + PW'(1);
      end else if (cmd.pstart) begin
        paddr <= PW'(rem);
        pend  <= 1'b0;
      end else if (cmd.probe) begin
        pend <= in_range;
        if (in_range) begin
          paddr <= paddr + PW'(1);
        end
      end
      if (cmd.ins_write) begin
        entry_count <= entry_count + RW'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op;
      key_r   <= key;
      value_r <= value;
    end
    if (cmd.hash) begin
      h <= h_next;
    end
    if (cmd.modr) begin
      rem <= r;
      msr <= mod_src << MOD_BITS_PER_CYCLE;
    end
    if (cmd.probe) begin
      pend_addr <= paddr[AW-1:0];
    end
    if (cmd.fin) begin
      res_status <= cmd.fin_status;
      res_value  <= cmd.fin_value ? rd_val : '0;
    end
    if (cmd.out_load) begin
      status      <= res_status;
      found_value <= res_value;
    end
  end

endmodule

// ===== hw/rtl/hkvr_checker.sv =====
// ----------------------------------------------------------------------------
// Hashed key/value registry checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "hashed_key_value_registry_defines.svh"

module hkvr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [63:0] found_value
);

  import hkvr_pkg::*;

  // A result not taken stays put.
  `HKVR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(found_value), "result changed while stalled")

  // Only a successful lookup carries a nonzero value.
  `HKVR_ASSERT_SAME(a_fail_zero, out_valid && status != ST_OK, found_value == '0, "failed item carries a value")

  // An accepted item keeps the block busy for at least the next cycle.
  `HKVR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after an accept")

endmodule

bind hashed_key_value_registry hkvr_checker u_checker (.*);
